>>> src/wrc_pkg.sv
// Package: constants, stage map and stage record of the wheel-rail creepage pipeline.
package wrc_pkg;

    localparam int FRAC          = 16;     // fraction bits of Q16.16 values
    localparam int TRIG_BITS     = 16;     // fraction bits of cosine and sine
    localparam int CORDIC_STEPS  = 16;
    localparam int CORDIC_GAIN   = 39797;
    localparam int PI_Q13        = 25736;
    localparam int HALF_PI_Q13   = 12868;
    localparam int MIN_REF_RESET = 6554;
    localparam int MIN_W         = 31;

    localparam int CS_W  = 19;             // CORDIC x/y
    localparam int Z_W   = 20;             // CORDIC residual angle, Q.16
    localparam int ROT_W = 36;             // rotated velocity/spin
    localparam int PRD_W = 51;             // trig times value
    localparam int DIV_BITS = 32;
    localparam int N_W   = ROT_W + FRAC;   // scaled numerator magnitude
    localparam int LANES = 3;

    localparam int ST_IN     = 0;
    localparam int ST_CORDIC = 1;
    localparam int ST_REF_MUL = 1;
    localparam int ST_REF_SUM = 2;
    localparam int ST_REF_FLR = 3;
    localparam int ST_FLIP   = ST_CORDIC + CORDIC_STEPS;
    localparam int ST_MUL    = ST_FLIP + 1;
    localparam int ST_SUM    = ST_MUL + 1;
    localparam int ST_DSET   = ST_SUM + 1;
    localparam int ST_DIV    = ST_DSET + 1;
    localparam int ST_FIN    = ST_DIV + DIV_BITS;
    localparam int N_STAGES  = ST_FIN + 1;

    localparam logic signed [Z_W-1:0] ATAN [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
        20'sd8, 20'sd4, 20'sd2
    };

    typedef struct packed {
        logic signed [CS_W-1:0]  x;
        logic signed [CS_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic                    flip;
        logic signed [31:0]      vx;
        logic signed [31:0]      vy;
        logic signed [31:0]      vz;
        logic signed [31:0]      wy;
        logic signed [31:0]      wz;
        logic signed [31:0]      pitch;
        logic signed [31:0]      arc;
        logic [15:0]             radius;
        logic signed [48:0]      prod;
        logic signed [33:0]      refw;
        logic signed [31:0]      ref_spd;
        logic signed [PRD_W-1:0] p_cvy;
        logic signed [PRD_W-1:0] p_svz;
        logic signed [PRD_W-1:0] p_swy;
        logic signed [PRD_W-1:0] p_cwz;
        logic signed [PRD_W-1:0] p_svy;
        logic signed [PRD_W-1:0] p_cvz;
        logic signed [ROT_W-1:0] lat;
        logic signed [ROT_W-1:0] spz;
        logic signed [31:0]      nrm;
        logic [31:0]             dvs;
        logic                    zdiv;
        logic [LANES-1:0]        neg;
        logic [LANES-1:0]        over;
        logic [LANES-1:0][31:0]  rem;
        logic [LANES-1:0][31:0]  low;
        logic [LANES-1:0][31:0]  quo;
        logic [LANES-1:0][31:0]  res;
        logic                    sat;
    } t_stage;

endpackage

>>> src/wrc_in_if.sv
// Interface: input channel of contact items.
interface wrc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] contact_angle;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic signed [31:0] rel_spin_y;
    logic signed [31:0] rel_spin_z;
    logic signed [31:0] pitch_rate;
    logic [15:0]        rolling_radius;
    logic signed [31:0] arc_rate;

    modport source (output valid, contact_angle, rel_vel_x, rel_vel_y, rel_vel_z,
                    rel_spin_y, rel_spin_z, pitch_rate, rolling_radius, arc_rate,
                    input ready);
    modport sink (input valid, contact_angle, rel_vel_x, rel_vel_y, rel_vel_z,
                  rel_spin_y, rel_spin_z, pitch_rate, rolling_radius, arc_rate,
                  output ready);
endinterface

>>> src/wrc_out_if.sv
// Interface: output channel of creepage results.
interface wrc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] longitudinal_creep;
    logic signed [31:0] lateral_creep;
    logic signed [31:0] spin_creep;
    logic signed [31:0] ref_speed;
    logic signed [31:0] normal_speed;
    logic               saturated;

    modport source (output valid, longitudinal_creep, lateral_creep, spin_creep,
                    ref_speed, normal_speed, saturated, input ready);
    modport sink (input valid, longitudinal_creep, lateral_creep, spin_creep,
                  ref_speed, normal_speed, saturated, output ready);
endinterface

>>> src/wheel_rail_creepage.sv
// Top level: pipelined wheel-rail creepage unit (CORDIC rotation, reference speed, dividers).
//
// One contact item per transfer, one result per item. The block is a 54-stage pipeline that
// takes a new item every cycle unless an untaken result in the output register holds it.
// Depth is set by the 16 CORDIC rotation stages and the 32 one-bit restoring division stages
// (three dividers run side by side). The last stage is the output register; when it holds a
// result that is not taken, the whole pipeline holds and input ready drops. Creepages are
// velocity x, rotated velocity y and rotated spin z over the floored reference speed, in
// Q16.16, truncated toward zero and clamped to 32 bits with the saturated flag; a zero
// reference speed (floor of zero only) gives zero creepages and saturated. Normal speed is
// clamped to 32 bits without the flag. The user must write min_reference_speed only while
// the block is idle; the block itself does not enforce this.
module wheel_rail_creepage (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [wrc_pkg::MIN_W-1:0] i_cfg_wr_data,
    wrc_in_if.sink                  i_in,
    wrc_out_if.source               o_out
);

    wrc_pkg::t_stage                r_pipe [wrc_pkg::N_STAGES];
    wrc_pkg::t_stage                n_pipe [wrc_pkg::N_STAGES];
    logic [wrc_pkg::N_STAGES-1:0]   r_vld;
    logic [wrc_pkg::N_STAGES-1:0]   n_vld;
    logic [wrc_pkg::MIN_W-1:0]      r_min_ref;
    logic                           w_en;

    // pipeline moves when the output register is empty or being taken
    assign w_en       = !r_vld[wrc_pkg::N_STAGES-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ref <= wrc_pkg::MIN_W'(wrc_pkg::MIN_REF_RESET);
        end else if (i_cfg_wr_en) begin
            r_min_ref <= i_cfg_wr_data;
        end
    end

    always_comb begin
        wrc_pkg::t_stage         st;
        logic signed [16:0]      a17;
        logic signed [wrc_pkg::CS_W-1:0] dx, dy;
        logic signed [50:0]      rsum;
        logic [34:0]             rmag;
        logic signed [34:0]      rflr;
        logic signed [51:0]      s_lat, s_spz, s_nrm;
        logic signed [wrc_pkg::ROT_W-1:0] nrm36;
        logic signed [wrc_pkg::ROT_W-1:0] num;
        logic [wrc_pkg::ROT_W-1:0] nmag;
        logic [wrc_pkg::N_W-1:0] nw;
        logic [32:0]             t;
        logic                    lsat;
        n_vld = {r_vld[wrc_pkg::N_STAGES-2:0], i_in.valid};
        for (int k = 0; k < wrc_pkg::N_STAGES; k++) begin
            a17   = '0;
            dx    = '0;
            dy    = '0;
            rsum  = '0;
            rmag  = '0;
            rflr  = '0;
            s_lat = '0;
            s_spz = '0;
            s_nrm = '0;
            nrm36 = '0;
            num   = '0;
            nmag  = '0;
            nw    = '0;
            t     = '0;
            lsat  = 1'b0;
            if (k == wrc_pkg::ST_IN) begin
                st        = r_pipe[0];
                st.vx     = i_in.rel_vel_x;
                st.vy     = i_in.rel_vel_y;
                st.vz     = i_in.rel_vel_z;
                st.wy     = i_in.rel_spin_y;
                st.wz     = i_in.rel_spin_z;
                st.pitch  = i_in.pitch_rate;
                st.arc    = i_in.arc_rate;
                st.radius = i_in.rolling_radius;
                a17       = 17'(i_in.contact_angle);
                st.flip   = 1'b0;
                if (i_in.contact_angle > wrc_pkg::HALF_PI_Q13) begin
                    a17     = a17 - 17'(wrc_pkg::PI_Q13);
                    st.flip = 1'b1;
                end else if (i_in.contact_angle < -wrc_pkg::HALF_PI_Q13) begin
                    a17     = a17 + 17'(wrc_pkg::PI_Q13);
                    st.flip = 1'b1;
                end
                st.z = wrc_pkg::Z_W'(a17) <<< 3;
                st.x = wrc_pkg::CS_W'(wrc_pkg::CORDIC_GAIN);
                st.y = '0;
            end else begin
                st = r_pipe[(k > 0) ? k - 1 : 0];
            end

            // reference speed, alongside the first CORDIC stages
            if (k == wrc_pkg::ST_REF_MUL) begin
                st.prod = $signed(st.pitch) * $signed({1'b0, st.radius});
            end
            if (k == wrc_pkg::ST_REF_SUM) begin
                rsum    = (51'(st.arc) <<< 16) - 51'(st.prod) + 51'sd65536;
                st.refw = 34'(rsum >>> 17);
            end
            if (k == wrc_pkg::ST_REF_FLR) begin
                rflr = 35'(st.refw);
                rmag = (rflr < 0) ? 35'(-rflr) : 35'(rflr);
                if (rmag < {4'b0, r_min_ref}) begin
                    rflr = (rflr < 0) ? -$signed({4'b0, r_min_ref})
                                      : $signed({4'b0, r_min_ref});
                end
                if (rflr > 35'sd2147483647) begin
                    st.ref_spd = 32'sh7fffffff;
                end else if (rflr < -35'sd2147483648) begin
                    st.ref_spd = 32'sh80000000;
                end else begin
                    st.ref_spd = 32'(rflr);
                end
            end

            if (k >= wrc_pkg::ST_CORDIC && k < wrc_pkg::ST_FLIP) begin
                dx = st.y >>> (k - wrc_pkg::ST_CORDIC);
                dy = st.x >>> (k - wrc_pkg::ST_CORDIC);
                if (st.z >= 0) begin
                    st.x = st.x - dx;
                    st.y = st.y + dy;
                    st.z = st.z - wrc_pkg::ATAN[k - wrc_pkg::ST_CORDIC];
                end else begin
                    st.x = st.x + dx;
                    st.y = st.y - dy;
                    st.z = st.z + wrc_pkg::ATAN[k - wrc_pkg::ST_CORDIC];
                end
            end

            // x holds cosine and y sine from here on
            if (k == wrc_pkg::ST_FLIP && st.flip) begin
                st.x = -st.x;
                st.y = -st.y;
            end

            if (k == wrc_pkg::ST_MUL) begin
                st.p_cvy = 51'(st.x) * 51'(st.vy);
                st.p_svz = 51'(st.y) * 51'(st.vz);
                st.p_swy = 51'(st.y) * 51'(st.wy);
                st.p_cwz = 51'(st.x) * 51'(st.wz);
                st.p_svy = 51'(st.y) * 51'(st.vy);
                st.p_cvz = 51'(st.x) * 51'(st.vz);
            end

            if (k == wrc_pkg::ST_SUM) begin
                s_lat  = 52'(st.p_cvy) + 52'(st.p_svz) + 52'sd32768;
                s_spz  = 52'(st.p_cwz) - 52'(st.p_swy) + 52'sd32768;
                s_nrm  = 52'(st.p_cvz) - 52'(st.p_svy) + 52'sd32768;
                st.lat = wrc_pkg::ROT_W'(s_lat >>> wrc_pkg::TRIG_BITS);
                st.spz = wrc_pkg::ROT_W'(s_spz >>> wrc_pkg::TRIG_BITS);
                nrm36  = wrc_pkg::ROT_W'(s_nrm >>> wrc_pkg::TRIG_BITS);
                if (nrm36 > 36'sd2147483647) begin
                    st.nrm = 32'sh7fffffff;
                end else if (nrm36 < -36'sd2147483648) begin
                    st.nrm = 32'sh80000000;
                end else begin
                    st.nrm = 32'(nrm36);
                end
            end

            if (k == wrc_pkg::ST_DSET) begin
                st.dvs  = (st.ref_spd < 0) ? 32'(-33'(st.ref_spd)) : 32'(st.ref_spd);
                st.zdiv = (st.ref_spd == 0);
                for (int l = 0; l < wrc_pkg::LANES; l++) begin
                    num = (l == 0) ? wrc_pkg::ROT_W'(st.vx) : ((l == 1) ? st.lat : st.spz);
                    nmag = (num < 0) ? wrc_pkg::ROT_W'(-num) : wrc_pkg::ROT_W'(num);
                    nw = wrc_pkg::N_W'(nmag) << wrc_pkg::FRAC;
                    st.neg[l]  = (num < 0) ^ (st.ref_spd < 0);
                    st.over[l] = (32'(nw[wrc_pkg::N_W-1:32]) >= st.dvs);
                    st.rem[l]  = 32'(nw[wrc_pkg::N_W-1:32]);
                    st.low[l]  = nw[31:0];
                    st.quo[l]  = '0;
                end
            end

            // one quotient bit per stage and lane
            if (k >= wrc_pkg::ST_DIV && k < wrc_pkg::ST_FIN) begin
                for (int l = 0; l < wrc_pkg::LANES; l++) begin
                    t = {st.rem[l], st.low[l][31]};
                    if (t >= {1'b0, st.dvs}) begin
                        st.rem[l] = 32'(t - {1'b0, st.dvs});
                        st.quo[l] = {st.quo[l][30:0], 1'b1};
                    end else begin
                        st.rem[l] = t[31:0];
                        st.quo[l] = {st.quo[l][30:0], 1'b0};
                    end
                    st.low[l] = {st.low[l][30:0], 1'b0};
                end
            end

            if (k == wrc_pkg::ST_FIN) begin
                st.sat = st.zdiv;
                for (int l = 0; l < wrc_pkg::LANES; l++) begin
                    if (st.zdiv) begin
                        lsat      = 1'b0;
                        st.res[l] = '0;
                    end else if (!st.neg[l]) begin
                        lsat      = st.over[l] | st.quo[l][31];
                        st.res[l] = lsat ? 32'h7fffffff : st.quo[l];
                    end else begin
                        lsat      = st.over[l] | (st.quo[l] > 32'h80000000);
                        st.res[l] = lsat ? 32'h80000000 : 32'(32'd0 - st.quo[l]);
                    end
                    st.sat = st.sat | lsat;
                end
            end

            n_pipe[k] = st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_out.valid              = r_vld[wrc_pkg::N_STAGES-1];
    assign o_out.longitudinal_creep = r_pipe[wrc_pkg::ST_FIN].res[0];
    assign o_out.lateral_creep      = r_pipe[wrc_pkg::ST_FIN].res[1];
    assign o_out.spin_creep         = r_pipe[wrc_pkg::ST_FIN].res[2];
    assign o_out.ref_speed          = r_pipe[wrc_pkg::ST_FIN].ref_spd;
    assign o_out.normal_speed       = r_pipe[wrc_pkg::ST_FIN].nrm;
    assign o_out.saturated          = r_pipe[wrc_pkg::ST_FIN].sat;

    // a held pipeline keeps its occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("stage valids moved during a stall");

    // an input transfer lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted item lost at pipeline entry");

    // zero divisor gives zero creepages and the flag
    a_zdiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ref_speed == 0 |->
            o_out.saturated && o_out.longitudinal_creep == 0 &&
            o_out.lateral_creep == 0 && o_out.spin_creep == 0)
        else $error("zero reference speed handled wrong");

    // a nonzero floor never lets the reference speed reach zero
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_min_ref != 0 |-> o_out.ref_speed != 0)
        else $error("reference speed below floor");

endmodule
